// File: src/bpt_pkg.sv
// Package for the beacon presence tracker: shared constants, codes and transfer types.
// No dependencies; imported by every module of the block.
`default_nettype none

package bpt_pkg;

    localparam int DEF_TABLE_DEPTH = 16;
    localparam int ADDR_W          = 48;
    localparam int UUID_W          = 64;
    localparam int LIMIT_W         = 9;
    localparam int CFG_IDX_W       = 2;
    localparam int CFG_DATA_W      = 64;

    localparam logic [7:0]  MIN_PAYLOAD_LEN = 8'd25;
    localparam logic [31:0] BEACON_HEADER   = 32'h4C00_0215;

    localparam logic [CFG_IDX_W-1:0] CFG_UUID_UPPER  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_UUID_LOWER  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LOSS_LIMIT  = 2'd2;

    localparam logic OP_ADVERT   = 1'b0;
    localparam logic OP_END_SCAN = 1'b1;

    localparam logic EV_LEFT    = 1'b0;
    localparam logic EV_ENTERED = 1'b1;

    typedef struct packed {
        logic               opcode;
        logic [ADDR_W-1:0]  device_address;
        logic [7:0]         payload_length;
        logic [31:0]        header_word;
        logic [UUID_W-1:0]  payload_uuid_upper;
        logic [UUID_W-1:0]  payload_uuid_lower;
        logic signed [7:0]  measured_power;
        logic signed [7:0]  tx_power;
    } t_in_item;

    typedef struct packed {
        logic               event_kind;
        logic [ADDR_W-1:0]  event_address;
        logic               last_of_run;
        logic               overflow_seen;
    } t_out_item;

endpackage

`default_nettype wire

// File: src/beacon_presence_tracker.sv
// Top level of the beacon presence tracker: sequencer, scan and tracked tables, output stage.
// Depends on bpt_pkg and bpt_filter.
//
// A kept advertisement enters S_ADV, which searches the scan set and inserts the address if it
// is new. An end-of-scan item matches tracked devices against the scan set (S_MATCH), reports
// new entries (S_ENT) and flushes the held event (S_FLUSH); it waits while the output is
// stalled. A single 48-bit address comparator steps through the scan table one entry per cycle
// when no event waits. Results pass through an output register, and one event is held back so
// that the final event of a run can be marked. Both tables start empty after reset.
`default_nettype none

module beacon_presence_tracker
    import bpt_pkg::*;
#(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire t_in_item              i_in_data,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output t_out_item                  o_out_data,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int IW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [CW-1:0] FULL = CW'(TABLE_DEPTH);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ADV,
        S_MATCH,
        S_ENT,
        S_FLUSH
    } t_state;

    t_state                 r_state, n_state;
    logic [CW-1:0]          r_i, n_i;
    logic [CW-1:0]          r_j, n_j;
    logic [CW-1:0]          r_kept, n_kept;
    logic [CW-1:0]          r_scan_cnt, n_scan_cnt;
    logic [CW-1:0]          r_trk_cnt, n_trk_cnt;
    logic [TABLE_DEPTH-1:0] r_matched, n_matched;
    logic                   r_ovf, n_ovf;
    logic [ADDR_W-1:0]      r_addr, n_addr;
    logic                   r_pend_vld, n_pend_vld;
    logic                   r_pend_kind, n_pend_kind;
    logic [ADDR_W-1:0]      r_pend_addr, n_pend_addr;
    logic                   r_out_vld, n_out_vld;
    t_out_item              r_out, n_out;

    logic [ADDR_W-1:0]      r_scan_mem [TABLE_DEPTH];
    logic [ADDR_W-1:0]      r_trk_mem [TABLE_DEPTH];
    logic [ADDR_W-1:0]      r_scan_q;
    logic [ADDR_W-1:0]      r_trk_q;

    logic                   w_keep;
    logic                   w_in_acc;
    logic                   w_out_free;
    logic                   w_can_push;
    logic                   w_push;
    logic                   w_push_kind;
    logic [ADDR_W-1:0]      w_push_addr;
    logic                   w_hit;
    logic                   w_scan_we;
    logic                   w_trk_we;
    logic [ADDR_W-1:0]      w_trk_wd;

    bpt_filter u_filter (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_item      (i_in_data),
        .o_keep      (w_keep)
    );

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;
    assign w_in_acc    = i_in_valid && (r_state == S_IDLE);
    assign w_out_free  = !r_out_vld || i_out_ready;
    assign w_can_push  = !r_pend_vld || w_out_free;
    assign w_hit       = (((r_state == S_ADV) ? r_addr : r_trk_q) == r_scan_q);

    always_comb begin
        n_state     = r_state;
        n_i         = r_i;
        n_j         = r_j;
        n_kept      = r_kept;
        n_scan_cnt  = r_scan_cnt;
        n_trk_cnt   = r_trk_cnt;
        n_matched   = r_matched;
        n_ovf       = r_ovf;
        n_addr      = r_addr;
        n_pend_vld  = r_pend_vld;
        n_pend_kind = r_pend_kind;
        n_pend_addr = r_pend_addr;
        n_out_vld   = r_out_vld;
        n_out       = r_out;
        w_push      = 1'b0;
        w_push_kind = EV_LEFT;
        w_push_addr = r_trk_q;
        w_scan_we   = 1'b0;
        w_trk_we    = 1'b0;
        w_trk_wd    = r_trk_q;

        if (r_out_vld && i_out_ready) begin
            n_out_vld = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_j    = '0;
                    n_addr = i_in_data.device_address;
                    if (i_in_data.opcode == OP_END_SCAN) begin
                        n_i       = '0;
                        n_kept    = '0;
                        n_matched = '0;
                        n_state   = S_MATCH;
                    end else if (w_keep) begin
                        n_state = S_ADV;
                    end
                end
            end
            S_ADV: begin
                if (r_j == r_scan_cnt) begin
                    if (r_scan_cnt != FULL) begin
                        w_scan_we  = 1'b1;
                        n_scan_cnt = r_scan_cnt + 1'b1;
                    end else begin
                        n_ovf = 1'b1;
                    end
                    n_state = S_IDLE;
                end else if (w_hit) begin
                    n_state = S_IDLE;
                end else begin
                    n_j = r_j + 1'b1;
                end
            end
            S_MATCH: begin
                if (r_i == r_trk_cnt) begin
                    n_j     = '0;
                    n_state = S_ENT;
                end else if (r_j == r_scan_cnt) begin
                    if (w_can_push) begin
                        w_push      = 1'b1;
                        w_push_kind = EV_LEFT;
                        w_push_addr = r_trk_q;
                        n_i         = r_i + 1'b1;
                        n_j         = '0;
                    end
                end else if (!r_matched[r_j[IW-1:0]] && w_hit) begin
                    n_matched[r_j[IW-1:0]] = 1'b1;
                    w_trk_we = 1'b1;
                    w_trk_wd = r_trk_q;
                    n_kept   = r_kept + 1'b1;
                    n_i      = r_i + 1'b1;
                    n_j      = '0;
                end else begin
                    n_j = r_j + 1'b1;
                end
            end
            S_ENT: begin
                if (r_j == r_scan_cnt) begin
                    n_trk_cnt  = r_kept;
                    n_scan_cnt = '0;
                    n_state    = S_FLUSH;
                end else if (r_matched[r_j[IW-1:0]]) begin
                    n_j = r_j + 1'b1;
                end else if (w_can_push) begin
                    w_push      = 1'b1;
                    w_push_kind = EV_ENTERED;
                    w_push_addr = r_scan_q;
                    if (r_kept != FULL) begin
                        w_trk_we = 1'b1;
                        w_trk_wd = r_scan_q;
                        n_kept   = r_kept + 1'b1;
                    end
                    n_j = r_j + 1'b1;
                end
            end
            S_FLUSH: begin
                if (!r_pend_vld) begin
                    n_state = S_IDLE;
                end else if (w_out_free) begin
                    n_out.event_kind    = r_pend_kind;
                    n_out.event_address = r_pend_addr;
                    n_out.last_of_run   = 1'b1;
                    n_out.overflow_seen = r_ovf;
                    n_out_vld           = 1'b1;
                    n_pend_vld          = 1'b0;
                    n_state             = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (w_push) begin
            if (r_pend_vld) begin
                n_out.event_kind    = r_pend_kind;
                n_out.event_address = r_pend_addr;
                n_out.last_of_run   = 1'b0;
                n_out.overflow_seen = r_ovf;
                n_out_vld           = 1'b1;
            end
            n_pend_vld  = 1'b1;
            n_pend_kind = w_push_kind;
            n_pend_addr = w_push_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_i        <= '0;
            r_j        <= '0;
            r_kept     <= '0;
            r_scan_cnt <= '0;
            r_trk_cnt  <= '0;
            r_matched  <= '0;
            r_ovf      <= 1'b0;
            r_pend_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_i        <= n_i;
            r_j        <= n_j;
            r_kept     <= n_kept;
            r_scan_cnt <= n_scan_cnt;
            r_trk_cnt  <= n_trk_cnt;
            r_matched  <= n_matched;
            r_ovf      <= n_ovf;
            r_pend_vld <= n_pend_vld;
            r_out_vld  <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr      <= n_addr;
        r_pend_kind <= n_pend_kind;
        r_pend_addr <= n_pend_addr;
        r_out       <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (w_scan_we) begin
            r_scan_mem[r_scan_cnt[IW-1:0]] <= r_addr;
        end
        r_scan_q <= r_scan_mem[n_j[IW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (w_trk_we) begin
            r_trk_mem[r_kept[IW-1:0]] <= w_trk_wd;
        end
        r_trk_q <= r_trk_mem[n_i[IW-1:0]];
    end

endmodule

`default_nettype wire

// File: src/bpt_filter.sv
// Configuration registers and the advertisement acceptance test.
// Depends on bpt_pkg for the item type, register indexes and header constants.
`default_nettype none

module bpt_filter
    import bpt_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_valid,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire t_in_item              i_item,
    output logic                       o_keep
);

    logic [UUID_W-1:0]        r_uuid_upper;
    logic [UUID_W-1:0]        r_uuid_lower;
    logic signed [LIMIT_W-1:0] r_loss_limit;
    logic signed [LIMIT_W-1:0] w_loss;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_uuid_upper <= '0;
            r_uuid_lower <= '0;
            r_loss_limit <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_UUID_UPPER: r_uuid_upper <= i_cfg_data;
                CFG_UUID_LOWER: r_uuid_lower <= i_cfg_data;
                CFG_LOSS_LIMIT: r_loss_limit <= i_cfg_data[LIMIT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign w_loss = $signed({i_item.tx_power[7], i_item.tx_power})
                  - $signed({i_item.measured_power[7], i_item.measured_power});

    assign o_keep = (i_item.payload_length >= MIN_PAYLOAD_LEN)
                 && (i_item.header_word == BEACON_HEADER)
                 && (i_item.payload_uuid_upper == r_uuid_upper)
                 && (i_item.payload_uuid_lower == r_uuid_lower)
                 && (w_loss <= r_loss_limit);

endmodule

`default_nettype wire

// File: src/bpt_checker.sv
// Port-level checker for the beacon presence tracker, bound to the top level.
// Depends on bpt_pkg for the transfer types and opcodes.
`default_nettype none

module bpt_checker
    import bpt_pkg::*;
(
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      i_in_valid,
    input wire logic      o_in_ready,
    input wire t_in_item  i_in_data,
    input wire logic      o_out_valid,
    input wire logic      i_out_ready,
    input wire t_out_item o_out_data
);

    logic w_in_xfer;

    assign w_in_xfer = i_in_valid && o_in_ready;

    // A result that waits is held unchanged until its transfer.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result changed or dropped while stalled");

    // An end of scan keeps the block busy for at least the following cycle.
    a_eos_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_xfer && (i_in_data.opcode == OP_END_SCAN) |=> !o_in_ready)
        else $error("ready straight after an end-of-scan transfer");

    // An advertisement never starts a result.
    a_adv_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_xfer && (i_in_data.opcode == OP_ADVERT) |=> !$rose(o_out_valid))
        else $error("result raised by an advertisement");

    // Once idle again, any result still waiting closes its run.
    a_idle_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready && o_out_valid |-> o_out_data.last_of_run)
        else $error("idle with an unfinished run of results");

endmodule

bind beacon_presence_tracker bpt_checker u_bpt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

`default_nettype wire

// File: bench/tb_beacon_presence_tracker.sv
// Self-checking testbench for beacon_presence_tracker: random-gap drivers, a transfer monitor and
// a predictor of the scan set, tracked table and presence events.
// Depends on bpt_pkg and the RTL of beacon_presence_tracker.

module tb_beacon_presence_tracker;

    timeunit 1ns;
    timeprecision 1ps;

    import bpt_pkg::*;

    localparam int TABLE_DEPTH    = DEF_TABLE_DEPTH;
    localparam int SETTLE_CYCLES  = 320;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int POOL_SIZE      = 40;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef enum int {BAD_LENGTH, BAD_HEADER, BAD_UUID_HI, BAD_UUID_LO, BAD_LOSS} t_advert_fault;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    t_in_item              in_data = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    t_out_item             out_data;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    logic [UUID_W-1:0]  cfg_uuid_upper = '0;
    logic [UUID_W-1:0]  cfg_uuid_lower = '0;
    logic signed [LIMIT_W-1:0] cfg_loss_limit = '0;

    logic [ADDR_W-1:0] tracked_list[$];
    logic [ADDR_W-1:0] scan_list[$];
    bit                overflow_sticky = 1'b0;
    t_out_item         expected_events[$];

    t_in_item          pending_items[$];
    logic [ADDR_W-1:0] addr_pool[POOL_SIZE];
    int                items_queued = 0;
    int                items_accepted = 0;
    int                mismatches = 0;
    int                send_gap = 0;
    int                recv_gap = 0;
    bit                idling = 1'b1;
    t_out_item         got_event;
    t_out_item         want_event;

    beacon_presence_tracker #(.TABLE_DEPTH(TABLE_DEPTH)) DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        forever #4 clk = ~clk;
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 4);
        return $urandom_range(10, 40);
    endfunction

    function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        case (idx)
            CFG_UUID_UPPER: begin
                cfg_uuid_upper = value;
            end
            CFG_UUID_LOWER: begin
                cfg_uuid_lower = value;
            end
            CFG_LOSS_LIMIT: begin
                cfg_loss_limit = value[LIMIT_W-1:0];
            end
            default: begin
            end
        endcase
    endfunction

    // Updates the scan set and tracked table for one accepted item and queues the events it causes.
    function automatic void track_item(t_in_item it);
        int tx_dbm;
        int meas_dbm;
        int lim;
        bit found;
        bit taken[$];
        logic [ADDR_W-1:0] next_tracked[$];
        t_out_item run[$];

        if (it.opcode == OP_ADVERT) begin
            tx_dbm = $signed(it.tx_power);
            meas_dbm = $signed(it.measured_power);
            lim = cfg_loss_limit;
            if (it.payload_length < MIN_PAYLOAD_LEN || it.header_word != BEACON_HEADER ||
                it.payload_uuid_upper != cfg_uuid_upper ||
                it.payload_uuid_lower != cfg_uuid_lower || tx_dbm - meas_dbm > lim)
                return;
            foreach (scan_list[j])
                if (scan_list[j] == it.device_address) return;
            if (scan_list.size() < TABLE_DEPTH) scan_list.insert(scan_list.size(), it.device_address);
            else overflow_sticky = 1'b1;
            return;
        end

        foreach (scan_list[j]) taken.insert(taken.size(), 1'b0);
        foreach (tracked_list[i]) begin
            found = 1'b0;
            foreach (scan_list[j]) begin
                if (!found && !taken[j] && scan_list[j] == tracked_list[i]) begin
                    taken[j] = 1'b1;
                    found = 1'b1;
                end
            end
            if (found) next_tracked.insert(next_tracked.size(), tracked_list[i]);
            else run.insert(run.size(), t_out_item'{event_kind: EV_LEFT,
                                                   event_address: tracked_list[i],
                                                   last_of_run: 1'b0,
                                                   overflow_seen: overflow_sticky});
        end
        foreach (scan_list[j]) begin
            if (!taken[j]) begin
                run.insert(run.size(), t_out_item'{event_kind: EV_ENTERED,
                                                  event_address: scan_list[j],
                                                  last_of_run: 1'b0,
                                                  overflow_seen: overflow_sticky});
                if (next_tracked.size() < TABLE_DEPTH)
                    next_tracked.insert(next_tracked.size(), scan_list[j]);
            end
        end
        if (run.size() > 0) run[run.size()-1].last_of_run = 1'b1;
        foreach (run[k]) expected_events.insert(expected_events.size(), run[k]);
        tracked_list = next_tracked;
        scan_list.delete();
    endfunction

    function automatic bit pick_power(input bit pass, output logic signed [7:0] meas,
                                      output logic signed [7:0] tx);
        int lim;
        int lo;
        int hi;
        int m;
        lim = cfg_loss_limit;
        meas = '0;
        tx = '0;
        if (pass) begin
            lo = (lim > 0) ? -128 : -128 - lim;
            m = lo + int'($urandom_range(0, 127 - lo));
            hi = (m + lim > 127) ? 127 : m + lim;
            meas = 8'(m);
            tx = ($urandom_range(0, 3) == 0) ? 8'(hi)
                                              : 8'(-128 + int'($urandom_range(0, hi + 128)));
            return 1'b1;
        end
        hi = (lim < -1) ? 127 : 126 - lim;
        if (hi < -128) return 1'b0;
        m = -128 + int'($urandom_range(0, hi + 128));
        lo = (m + lim + 1 < -128) ? -128 : m + lim + 1;
        meas = 8'(m);
        tx = ($urandom_range(0, 3) == 0) ? 8'(lo) : 8'(lo + int'($urandom_range(0, 127 - lo)));
        return 1'b1;
    endfunction

    function automatic t_in_item random_item(logic op);
        t_in_item it;
        it.opcode             = op;
        it.device_address     = {16'($urandom), 32'($urandom)};
        it.payload_length     = 8'($urandom);
        it.header_word        = $urandom;
        it.payload_uuid_upper = rand64();
        it.payload_uuid_lower = rand64();
        it.measured_power     = 8'($urandom);
        it.tx_power           = 8'($urandom);
        return it;
    endfunction

    function automatic t_in_item directed_advert(logic [ADDR_W-1:0] addr, int len, int meas,
                                                 int tx);
        t_in_item it;
        it = random_item(OP_ADVERT);
        it.device_address     = addr;
        it.payload_length     = 8'(len);
        it.header_word        = BEACON_HEADER;
        it.payload_uuid_upper = cfg_uuid_upper;
        it.payload_uuid_lower = cfg_uuid_lower;
        it.measured_power     = 8'(meas);
        it.tx_power           = 8'(tx);
        return it;
    endfunction

    function automatic t_in_item good_advert(logic [ADDR_W-1:0] addr);
        t_in_item it;
        it = random_item(OP_ADVERT);
        it.device_address     = addr;
        it.payload_length     = ($urandom_range(0, 3) == 0) ? MIN_PAYLOAD_LEN
                                                             : 8'($urandom_range(25, 255));
        it.header_word        = BEACON_HEADER;
        it.payload_uuid_upper = cfg_uuid_upper;
        it.payload_uuid_lower = cfg_uuid_lower;
        void'(pick_power(1'b1, it.measured_power, it.tx_power));
        return it;
    endfunction

    function automatic t_in_item broken_advert(logic [ADDR_W-1:0] addr);
        t_in_item it;
        t_advert_fault fault;
        it = good_advert(addr);
        fault = t_advert_fault'($urandom_range(0, 4));
        case (fault)
            BAD_HEADER: begin
                it.header_word ^= 32'd1 << $urandom_range(0, 31);
            end
            BAD_UUID_HI: begin
                it.payload_uuid_upper ^= 64'd1 << $urandom_range(0, 63);
            end
            BAD_UUID_LO: begin
                it.payload_uuid_lower ^= 64'd1 << $urandom_range(0, 63);
            end
            BAD_LOSS: begin
                if (!pick_power(1'b0, it.measured_power, it.tx_power))
                    it.payload_length = 8'($urandom_range(0, 24));
            end
            default: begin
                it.payload_length = 8'($urandom_range(0, 24));
            end
        endcase
        return it;
    endfunction

    function automatic void send(t_in_item it);
        pending_items.insert(pending_items.size(), it);
        items_queued++;
    endfunction

    // Scans of random length over a pool of addresses, each closed by an end of scan.
    function automatic void make_scans(int n, int max_len, int span);
        int made;
        int len;
        int r;
        logic [ADDR_W-1:0] addr;
        made = 0;
        while (made < n) begin
            len = $urandom_range(0, max_len);
            repeat (len) begin
                r = $urandom_range(0, 99);
                addr = addr_pool[$urandom_range(0, span - 1)];
                if (r < 75) begin
                    send(good_advert(addr));
                    made++;
                end else if (r < 92) begin
                    send(broken_advert(addr));
                    made++;
                end else begin
                    send(random_item(OP_ADVERT));
                end
            end
            send(random_item(OP_END_SCAN));
            made++;
        end
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        apply_reg(idx, value);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_config(logic [63:0] upper, logic [63:0] lower, int lim);
        write_reg(CFG_UUID_UPPER, upper);
        write_reg(CFG_UUID_LOWER, lower);
        write_reg(CFG_LOSS_LIMIT, 64'(lim));
    endtask

    task automatic wait_quiet();
        do @(posedge clk); while (items_accepted != items_queued || expected_events.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic report_field(string field, logic [ADDR_W-1:0] want, logic [ADDR_W-1:0] got);
        $display("%0t ns: %s mismatch, expected %h, got %h", $time, field, want, got);
        mismatches++;
    endtask

    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && in_ready) begin
                track_item(in_data);
                items_accepted++;
            end
            if (!(in_valid && !in_ready)) begin
                if (send_gap > 0) begin
                    send_gap--;
                    in_valid <= 1'b0;
                end else if (pending_items.size() > 0) begin
                    in_valid <= 1'b1;
                    in_data  <= pending_items.pop_front();
                    send_gap = idling ? pick_gap() : 0;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_valid && out_ready) begin
                got_event = out_data;
                if (expected_events.size() == 0) begin
                    $display("%0t ns: unexpected event, expected none, got kind %0d address %h",
                             $time, got_event.event_kind, got_event.event_address);
                    mismatches++;
                end else begin
                    want_event = expected_events.pop_front();
                    if (got_event.event_kind !== want_event.event_kind)
                        report_field("event_kind", want_event.event_kind, got_event.event_kind);
                    if (got_event.event_address !== want_event.event_address)
                        report_field("event_address", want_event.event_address,
                                     got_event.event_address);
                    if (got_event.last_of_run !== want_event.last_of_run)
                        report_field("last_of_run", want_event.last_of_run,
                                     got_event.last_of_run);
                    if (got_event.overflow_seen !== want_event.overflow_seen)
                        report_field("overflow_seen", want_event.overflow_seen,
                                     got_event.overflow_seen);
                end
            end
            if (recv_gap > 0) begin
                recv_gap--;
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
                if (idling && $urandom_range(0, 3) == 0) recv_gap = pick_gap();
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("== FAIL ==");
        $finish;
    end

    initial begin : stimulus
        logic [ADDR_W-1:0] a1;
        logic [ADDR_W-1:0] a2;
        logic [ADDR_W-1:0] a3;
        t_in_item it;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        for (int i = 0; i < POOL_SIZE; i++) addr_pool[i] = {16'($urandom), 32'($urandom)};
        a1 = addr_pool[0];
        a2 = addr_pool[1];
        a3 = addr_pool[2];

        // Directed part: filter boundaries, duplicates and the ordering of exits and entries.
        write_reg(CFG_UNUSED, rand64());
        set_config(rand64(), rand64(), 20);
        send(random_item(OP_END_SCAN));
        send(directed_advert(a1, 25, -60, -40));
        send(directed_advert(a2, 24, -60, -60));
        it = directed_advert(a2, 40, -60, -60);
        it.header_word ^= 32'h1;
        send(it);
        it.header_word = '0;
        send(it);
        it = directed_advert(a2, 40, -60, -60);
        it.payload_uuid_upper ^= 64'h8000_0000_0000_0000;
        send(it);
        it = directed_advert(a2, 40, -60, -60);
        it.payload_uuid_lower ^= 64'h1;
        send(it);
        send(directed_advert(a2, 30, -60, -39));
        send(directed_advert(a1, 255, 0, 0));
        send(directed_advert(a3, 255, -128, 127));
        send(directed_advert('1, 200, 127, -128));
        send(directed_advert('0, 25, 0, 20));
        send(directed_advert(a2, 100, -100, -80));
        send(random_item(OP_END_SCAN));
        send(directed_advert(a1, 60, -70, -70));
        send(directed_advert(a3, 60, -70, -70));
        send(random_item(OP_END_SCAN));
        send(random_item(OP_END_SCAN));
        wait_quiet();

        set_config(rand64(), rand64(), 255);
        make_scans(90, 14, 24);
        wait_quiet();

        set_config('0, '0, -255);
        make_scans(60, 14, 24);
        wait_quiet();

        idling = 1'b0;
        set_config('1, '1, int'($urandom_range(0, 510)) - 255);
        make_scans(70, 14, 24);
        wait_quiet();
        idling = 1'b1;

        for (int i = 0; i < 8; i++)
            addr_pool[$urandom_range(0, 23)] = {16'($urandom), 32'($urandom)};
        set_config(rand64(), rand64(), int'($urandom_range(0, 80)) - 40);
        make_scans(90, 14, 24);
        wait_quiet();

        // Scans larger than the table, so the sticky overflow flag comes into play.
        set_config(rand64(), rand64(), 100);
        make_scans(110, 30, POOL_SIZE);
        wait_quiet();

        if (mismatches == 0 && expected_events.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// File: beacon_presence_tracker.f
src/bpt_pkg.sv
src/bpt_filter.sv
src/beacon_presence_tracker.sv
src/bpt_checker.sv
bench/tb_beacon_presence_tracker.sv
